@@ sv/pairwise_gravity_delta_v_assert.svh @@
// assertion macros used by the checker file of pairwise_gravity_delta_v
// no dependencies; include by bare file name
`ifndef PAIRWISE_GRAVITY_DELTA_V_ASSERT_SVH
`define PAIRWISE_GRAVITY_DELTA_V_ASSERT_SVH

// same-cycle implication
`define PGD_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pgd assertion failed");

// next-cycle implication
`define PGD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pgd assertion failed");

`endif

@@ sv/pgd_pkg.sv @@
// shared widths and types for the pairwise gravity delta block
// no dependencies
package pgd_pkg;

   localparam int PosW      = 32;
   localparam int DiffW     = PosW + 1;          // exact difference of two positions
   localparam int GmW       = 32;
   localparam int StepW     = 32;
   localparam int OutW      = 48;
   localparam int SumW      = 2 * DiffW;         // r^2 < 3 * 2^64
   localparam int SqW       = 2 * SumW;          // r^4
   localparam int CubeW     = 3 * SumW;          // r^6
   localparam int ProdW     = DiffW + StepW + GmW;
   localparam int NormSh    = 7;                 // 2^24 out, 2^-16 step, halving
   localparam int NW        = ProdW + NormSh;
   localparam int MW        = 2 * NW;
   localparam int MulXW     = SqW + NW;
   localparam int MulYW     = NW;
   localparam int CntW      = 7;
   localparam int QW        = OutW;
   localparam int BitW      = 6;
   localparam int RootSh    = 2 * (QW - 1);
   localparam int BW        = CubeW + RootSh;
   localparam int AW        = CubeW + 2 * QW;
   localparam int CmpW      = AW + 1;
   localparam int FifoDepth = 4;
   localparam int FifoAw    = 2;

   localparam logic [CntW-1:0] LenDiff = CntW'(DiffW);
   localparam logic [CntW-1:0] LenSum  = CntW'(SumW);
   localparam logic [CntW-1:0] LenWord = CntW'(GmW);
   localparam logic [CntW-1:0] LenN    = CntW'(NW);

   typedef struct packed {
      logic [2:0][DiffW-1:0] d;
      logic [GmW-1:0]        gma;
      logic [GmW-1:0]        gmb;
      logic [StepW-1:0]      ts;
      logic                  coin;
   } entry_type;

   function automatic logic [DiffW-1:0] abs_diff(input logic [DiffW-1:0] v);
      logic [DiffW-1:0] r;
      r = v[DiffW-1] ? (~v + DiffW'(1)) : v;
      return r;
   endfunction

endpackage

@@ sv/pgd_if.sv @@
// request and response channel interfaces for pairwise_gravity_delta_v
// depends on pgd_pkg
interface pgd_req_if;
   import pgd_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [PosW-1:0]  pos_ax;
   logic signed [PosW-1:0]  pos_ay;
   logic signed [PosW-1:0]  pos_az;
   logic signed [PosW-1:0]  pos_bx;
   logic signed [PosW-1:0]  pos_by;
   logic signed [PosW-1:0]  pos_bz;
   logic [GmW-1:0]          gmass_a;
   logic [GmW-1:0]          gmass_b;
   logic [StepW-1:0]        time_step;

   modport source (output valid, pos_ax, pos_ay, pos_az, pos_bx, pos_by, pos_bz,
                   gmass_a, gmass_b, time_step, input ready);
   modport sink (input valid, pos_ax, pos_ay, pos_az, pos_bx, pos_by, pos_bz,
                 gmass_a, gmass_b, time_step, output ready);
endinterface

interface pgd_rsp_if;
   import pgd_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [OutW-1:0]  dv_ax;
   logic signed [OutW-1:0]  dv_ay;
   logic signed [OutW-1:0]  dv_az;
   logic signed [OutW-1:0]  dv_bx;
   logic signed [OutW-1:0]  dv_by;
   logic signed [OutW-1:0]  dv_bz;
   logic                    coincident;
   logic                    saturated;

   modport source (output valid, dv_ax, dv_ay, dv_az, dv_bx, dv_by, dv_bz,
                   coincident, saturated, input ready);
   modport sink (input valid, dv_ax, dv_ay, dv_az, dv_bx, dv_by, dv_bz,
                 coincident, saturated, output ready);
endinterface

@@ sv/pgd_front.sv @@
// front end: takes a body pair, forms the exact displacements and the
// coincidence flag, and holds the entry for the queue; depends on pgd_pkg, pgd_if
module pgd_front (
   input  logic              clock,
   input  logic              reset,
   pgd_req_if.sink           req_ch,
   output pgd_pkg::entry_type ent_out,
   output logic              ent_valid,
   input  logic              ent_ready
);
   import pgd_pkg::*;

   entry_type        ent_ff, ent_in;
   logic             valid_ff, valid_in;
   logic             take;
   logic [DiffW-1:0] dx, dy, dz;

   assign req_ch.ready = !valid_ff || ent_ready;
   assign take = req_ch.valid && req_ch.ready;

   assign dx = {req_ch.pos_ax[PosW-1], req_ch.pos_ax} - {req_ch.pos_bx[PosW-1], req_ch.pos_bx};
   assign dy = {req_ch.pos_ay[PosW-1], req_ch.pos_ay} - {req_ch.pos_by[PosW-1], req_ch.pos_by};
   assign dz = {req_ch.pos_az[PosW-1], req_ch.pos_az} - {req_ch.pos_bz[PosW-1], req_ch.pos_bz};

   always_comb begin
      ent_in   = ent_ff;
      valid_in = valid_ff;
      if (valid_ff && ent_ready) begin
         valid_in = 1'b0;
      end
      if (take) begin
         valid_in    = 1'b1;
         ent_in.d[0] = dx;
         ent_in.d[1] = dy;
         ent_in.d[2] = dz;
         ent_in.gma  = req_ch.gmass_a;
         ent_in.gmb  = req_ch.gmass_b;
         ent_in.ts   = req_ch.time_step;
         ent_in.coin = (dx == '0) && (dy == '0) && (dz == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   assign ent_out   = ent_ff;
   assign ent_valid = valid_ff;

endmodule

@@ sv/pgd_fifo.sv @@
// short queue of classified pairs between front end and compute engine
// depends on pgd_pkg
module pgd_fifo (
   input  logic               clock,
   input  logic               reset,
   input  pgd_pkg::entry_type push_data,
   input  logic               push_valid,
   output logic               push_ready,
   output pgd_pkg::entry_type pop_data,
   output logic               pop_valid,
   input  logic               pop_ready
);
   import pgd_pkg::*;

   entry_type         mem_ff [FifoDepth];
   logic [FifoAw-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [FifoAw:0]   count_ff, count_in;
   logic              push, pop;

   assign push_ready = (count_ff != (FifoAw+1)'(FifoDepth));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = mem_ff[rd_ff];

   always_comb begin
      wr_in    = push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + (FifoAw+1)'(push) - (FifoAw+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

@@ sv/pgd_core.sv @@
// compute engine: shift-add multiplier and exact 48-step root search,
// sequenced per component, with the result register; depends on pgd_pkg, pgd_if
module pgd_core (
   input  logic               clock,
   input  logic               reset,
   input  pgd_pkg::entry_type ent,
   input  logic               ent_valid,
   output logic               ent_pop,
   pgd_rsp_if.source          rsp_ch
);
   import pgd_pkg::*;

   localparam logic [3:0] StIdle  = 4'd0;
   localparam logic [3:0] StSq    = 4'd1;
   localparam logic [3:0] StS2    = 4'd2;
   localparam logic [3:0] StS3    = 4'd3;
   localparam logic [3:0] StNt    = 4'd4;
   localparam logic [3:0] StNg    = 4'd5;
   localparam logic [3:0] StNn    = 4'd6;
   localparam logic [3:0] StRoot  = 4'd7;
   localparam logic [3:0] StStore = 4'd8;
   localparam logic [3:0] StDone  = 4'd9;

   localparam logic [QW-1:0] LimPos = {1'b0, {(QW-1){1'b1}}};
   localparam logic [QW-1:0] LimNeg = {1'b1, {(QW-1){1'b0}}};

   logic [3:0]       state_ff, state_in;
   logic             phase_ff, phase_in;
   logic [1:0]       axis_ff, axis_in;
   logic             body_ff, body_in;
   logic [BitW-1:0]  bit_ff, bit_in;
   logic [CntW-1:0]  mcnt_ff, mcnt_in;
   logic [MulXW-1:0] mx_ff, mx_in, acc_ff, acc_in;
   logic [MulYW-1:0] my_ff, my_in;
   entry_type        item_ff, item_in;
   logic [SumW-1:0]  s_ff, s_in;
   logic [CubeW-1:0] s3_ff, s3_in;
   logic [NW-1:0]    n_ff, n_in;
   logic [MW-1:0]    e_ff, e_in;
   logic [AW-1:0]    a_ff, a_in, a_next;
   logic [BW-1:0]    b_ff, b_in;
   logic [QW-1:0]    q_ff, q_in;
   logic [QW-1:0]    res_ff [2][3];
   logic [QW-1:0]    res_in [2][3];
   logic             sat_ff, sat_in;
   logic             rv_ff, rv_in;
   logic [QW-1:0]    odv_ff [6];
   logic [QW-1:0]    odv_in [6];
   logic             ocoin_ff, ocoin_in, osat_ff, osat_in;

   logic [DiffW-1:0] dsel, mag;
   logic             neg;
   logic [GmW-1:0]   gm_sel;
   logic [CmpW-1:0]  sum_w;
   logic             take;
   logic [QW-1:0]    clip_q, signed_q;
   logic             clip;
   logic             mul_done;

   assign dsel     = item_ff.d[axis_ff];
   assign mag      = abs_diff(dsel);
   assign neg      = body_ff ? dsel[DiffW-1] : (!dsel[DiffW-1] && (dsel != '0));
   assign gm_sel   = body_ff ? item_ff.gma : item_ff.gmb;
   assign mul_done = phase_ff && (mcnt_ff == '0);

   // one trial bit of the root: accept while q^2 * r^6 stays within N^2
   assign sum_w  = {1'b0, a_ff} + CmpW'(b_ff);
   assign take   = (CmpW'(e_ff) >= sum_w);
   assign a_next = take ? a_ff + AW'({b_ff, 1'b0}) : a_ff;

   always_comb begin
      if (!neg) begin
         clip     = (q_ff > LimPos);
         clip_q   = clip ? LimPos : q_ff;
         signed_q = clip_q;
      end else begin
         clip     = (q_ff > LimNeg);
         clip_q   = clip ? LimNeg : q_ff;
         signed_q = '0 - clip_q;
      end
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      axis_in  = axis_ff;
      body_in  = body_ff;
      bit_in   = bit_ff;
      mcnt_in  = mcnt_ff;
      mx_in    = mx_ff;
      my_in    = my_ff;
      acc_in   = acc_ff;
      item_in  = item_ff;
      s_in     = s_ff;
      s3_in    = s3_ff;
      n_in     = n_ff;
      e_in     = e_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      q_in     = q_ff;
      res_in   = res_ff;
      sat_in   = sat_ff;
      rv_in    = rv_ff;
      odv_in   = odv_ff;
      ocoin_in = ocoin_ff;
      osat_in  = osat_ff;
      ent_pop  = 1'b0;

      // shift-add multiplier, one partial product per cycle
      if (mcnt_ff != '0) begin
         acc_in  = acc_ff + (my_ff[0] ? mx_ff : '0);
         mx_in   = mx_ff << 1;
         my_in   = my_ff >> 1;
         mcnt_in = mcnt_ff - 1'b1;
      end

      if (rv_ff && rsp_ch.ready) begin
         rv_in = 1'b0;
      end

      unique case (state_ff)
         StIdle: begin
            if (ent_valid) begin
               ent_pop  = 1'b1;
               item_in  = ent;
               s_in     = '0;
               sat_in   = 1'b0;
               axis_in  = '0;
               body_in  = 1'b0;
               phase_in = 1'b0;
               state_in = ent.coin ? StDone : StSq;
            end
         end
         StSq: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
               acc_in   = '0;
               mx_in    = MulXW'(mag);
               my_in    = MulYW'(mag);
               mcnt_in  = LenDiff;
            end else if (mul_done) begin
               phase_in = 1'b0;
               s_in     = s_ff + acc_ff[SumW-1:0];
               if (axis_ff == 2'd2) begin
                  axis_in  = '0;
                  state_in = StS2;
               end else begin
                  axis_in = axis_ff + 1'b1;
               end
            end
         end
         StS2: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
               acc_in   = '0;
               mx_in    = MulXW'(s_ff);
               my_in    = MulYW'(s_ff);
               mcnt_in  = LenSum;
            end else if (mul_done) begin
               phase_in = 1'b0;
               s3_in    = CubeW'(acc_ff[SqW-1:0]);
               state_in = StS3;
            end
         end
         StS3: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
               acc_in   = '0;
               mx_in    = MulXW'(s3_ff[SqW-1:0]);
               my_in    = MulYW'(s_ff);
               mcnt_in  = LenSum;
            end else if (mul_done) begin
               phase_in = 1'b0;
               s3_in    = acc_ff[CubeW-1:0];
               axis_in  = '0;
               body_in  = 1'b0;
               state_in = StNt;
            end
         end
         StNt: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
               acc_in   = '0;
               mx_in    = MulXW'(mag);
               my_in    = MulYW'(item_ff.ts);
               mcnt_in  = LenWord;
            end else if (mul_done) begin
               phase_in = 1'b0;
               n_in     = NW'(acc_ff[DiffW+StepW-1:0]);
               state_in = StNg;
            end
         end
         StNg: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
               acc_in   = '0;
               mx_in    = MulXW'(n_ff);
               my_in    = MulYW'(gm_sel);
               mcnt_in  = LenWord;
            end else if (mul_done) begin
               phase_in = 1'b0;
               n_in     = {acc_ff[ProdW-1:0], {NormSh{1'b0}}};
               state_in = StNn;
            end
         end
         StNn: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
               acc_in   = '0;
               mx_in    = MulXW'(n_ff);
               my_in    = n_ff;
               mcnt_in  = LenN;
            end else if (mul_done) begin
               phase_in = 1'b0;
               e_in     = acc_ff[MW-1:0];
               a_in     = '0;
               b_in     = {s3_ff, {RootSh{1'b0}}};
               q_in     = '0;
               bit_in   = BitW'(QW - 1);
               state_in = StRoot;
            end
         end
         StRoot: begin
            if (take) begin
               e_in = e_ff - sum_w[MW-1:0];
               q_in = q_ff | (QW'(1) << bit_ff);
            end
            a_in = a_next >> 1;
            b_in = b_ff >> 2;
            if (bit_ff == '0) begin
               state_in = StStore;
            end else begin
               bit_in = bit_ff - 1'b1;
            end
         end
         StStore: begin
            res_in[body_ff][axis_ff] = signed_q;
            sat_in = sat_ff | clip;
            state_in = StNt;
            if (axis_ff == 2'd2) begin
               axis_in = '0;
               body_in = 1'b1;
               if (body_ff) begin
                  state_in = StDone;
               end
            end else begin
               axis_in = axis_ff + 1'b1;
            end
         end
         StDone: begin
            if (!rv_ff || rsp_ch.ready) begin
               rv_in    = 1'b1;
               ocoin_in = item_ff.coin;
               osat_in  = item_ff.coin ? 1'b0 : sat_ff;
               for (int i = 0; i < 3; i++) begin
                  odv_in[i]     = item_ff.coin ? '0 : res_ff[0][i];
                  odv_in[i + 3] = item_ff.coin ? '0 : res_ff[1][i];
               end
               state_in = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         phase_ff <= 1'b0;
         mcnt_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         mcnt_ff  <= mcnt_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      axis_ff  <= axis_in;
      body_ff  <= body_in;
      bit_ff   <= bit_in;
      mx_ff    <= mx_in;
      my_ff    <= my_in;
      acc_ff   <= acc_in;
      item_ff  <= item_in;
      s_ff     <= s_in;
      s3_ff    <= s3_in;
      n_ff     <= n_in;
      e_ff     <= e_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      q_ff     <= q_in;
      res_ff   <= res_in;
      sat_ff   <= sat_in;
      odv_ff   <= odv_in;
      ocoin_ff <= ocoin_in;
      osat_ff  <= osat_in;
   end

   assign rsp_ch.valid      = rv_ff;
   assign rsp_ch.dv_ax      = $signed(odv_ff[0]);
   assign rsp_ch.dv_ay      = $signed(odv_ff[1]);
   assign rsp_ch.dv_az      = $signed(odv_ff[2]);
   assign rsp_ch.dv_bx      = $signed(odv_ff[3]);
   assign rsp_ch.dv_by      = $signed(odv_ff[4]);
   assign rsp_ch.dv_bz      = $signed(odv_ff[5]);
   assign rsp_ch.coincident = ocoin_ff;
   assign rsp_ch.saturated  = osat_ff;

endmodule

@@ sv/pairwise_gravity_delta_v.sv @@
// pairwise_gravity_delta_v: half-step gravitational velocity change of a body pair.
// req_ch carries two signed positions, both G*m values and a Q16.16 time step;
// a transfer happens when valid and ready are high at a rising clock edge.
// rsp_ch returns one item per request: six Q24.24 velocity changes (body a gets
// -d*k(gm_b), body b gets +d*k(gm_a)), a coincident flag and a saturated flag.
// The front end takes a pair into a holding register and a four-deep queue,
// so several pairs can be taken while the engine is busy. The engine works
// one pair at a time, using the shared shift-add multiplier (one partial
// product per cycle, 23 products) and the 48-step root search per component;
// coincident pairs skip both. The result sits in an output register until
// rsp_ch.ready; the engine waits there at the end of the next pair, and the
// queue keeps taking pairs until it fills. Synchronous reset empties the
// queue and drops any pending result; no clearing pass is needed.
// depends on pgd_pkg, pgd_if, pgd_front, pgd_fifo, pgd_core
module pairwise_gravity_delta_v (
   input  logic      clock,
   input  logic      reset,
   pgd_req_if.sink   req_ch,
   pgd_rsp_if.source rsp_ch
);
   import pgd_pkg::*;

   entry_type front_ent, queue_ent;
   logic      front_valid, front_ready;
   logic      queue_valid, queue_pop;

   pgd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .ent_out   (front_ent),
      .ent_valid (front_valid),
      .ent_ready (front_ready)
   );

   pgd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_data  (front_ent),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .pop_data   (queue_ent),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_pop)
   );

   pgd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .ent       (queue_ent),
      .ent_valid (queue_valid),
      .ent_pop   (queue_pop),
      .rsp_ch    (rsp_ch)
   );

endmodule

@@ sv/pgd_checker.sv @@
// port-level checks on the response channel of pairwise_gravity_delta_v
// depends on pgd_pkg and pairwise_gravity_delta_v_assert.svh; bound to the top level
`include "pairwise_gravity_delta_v_assert.svh"

module pgd_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [pgd_pkg::OutW-1:0]  dv_ax,
   input logic [pgd_pkg::OutW-1:0]  dv_ay,
   input logic [pgd_pkg::OutW-1:0]  dv_az,
   input logic [pgd_pkg::OutW-1:0]  dv_bx,
   input logic [pgd_pkg::OutW-1:0]  dv_by,
   input logic [pgd_pkg::OutW-1:0]  dv_bz,
   input logic                      coincident,
   input logic                      saturated
);
   import pgd_pkg::*;

   localparam logic [OutW-1:0] Max = {1'b0, {(OutW-1){1'b1}}};
   localparam logic [OutW-1:0] Min = {1'b1, {(OutW-1){1'b0}}};

   logic all_zero, lim_hit;

   assign all_zero = (dv_ax == '0) && (dv_ay == '0) && (dv_az == '0) &&
                     (dv_bx == '0) && (dv_by == '0) && (dv_bz == '0);
   assign lim_hit  = (dv_ax == Max) || (dv_ax == Min) || (dv_ay == Max) || (dv_ay == Min) ||
                     (dv_az == Max) || (dv_az == Min) || (dv_bx == Max) || (dv_bx == Min) ||
                     (dv_by == Max) || (dv_by == Min) || (dv_bz == Max) || (dv_bz == Min);

   `PGD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `PGD_ASSERT_IMPLY(a_coin_zero, clock, reset, rsp_valid && coincident, all_zero && !saturated)
   `PGD_ASSERT_IMPLY(a_sat_limit, clock, reset, rsp_valid && saturated, lim_hit)
   `PGD_ASSERT_IMPLY(a_pair_sign, clock, reset, rsp_valid && !saturated,
      (dv_ax == '0 || dv_bx == '0 || dv_ax[OutW-1] != dv_bx[OutW-1]) &&
      (dv_ay == '0 || dv_by == '0 || dv_ay[OutW-1] != dv_by[OutW-1]) &&
      (dv_az == '0 || dv_bz == '0 || dv_az[OutW-1] != dv_bz[OutW-1]))

endmodule

bind pairwise_gravity_delta_v pgd_checker u_pgd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .dv_ax      (rsp_ch.dv_ax),
   .dv_ay      (rsp_ch.dv_ay),
   .dv_az      (rsp_ch.dv_az),
   .dv_bx      (rsp_ch.dv_bx),
   .dv_by      (rsp_ch.dv_by),
   .dv_bz      (rsp_ch.dv_bz),
   .coincident (rsp_ch.coincident),
   .saturated  (rsp_ch.saturated)
);

@@ verif/pairwise_gravity_delta_v_test.sv @@
// testbench for pairwise_gravity_delta_v: directed and random body pairs with an exact predictor
// depends on pgd_pkg, pgd_if and the pairwise_gravity_delta_v rtl
`timescale 1ns / 100ps

module pairwise_gravity_delta_v_test;
   import pgd_pkg::*;

   localparam int WideW    = 320;
   localparam int WatchMax = 20000;
   localparam int PosMin   = 32'sh8000_0000;

   typedef struct {
      logic signed [PosW-1:0] pa [3];
      logic signed [PosW-1:0] pb [3];
      logic [GmW-1:0]         gma;
      logic [GmW-1:0]         gmb;
      logic [StepW-1:0]       ts;
   } pair_type;

   typedef struct {
      logic [OutW-1:0] dv [6];
      logic            coin;
      logic            sat;
   } delta_type;

   logic clock;
   logic reset;
   pgd_req_if req_ch ();
   pgd_rsp_if rsp_ch ();

   pairwise_gravity_delta_v dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   delta_type expected_deltas [$];
   int        error_count;
   int        quiet_cycles;
   bit        no_gaps;
   int        stall_left;

   always #1 clock = ~clock;

   // one velocity component, truncated magnitude then sign and clipping
   function automatic logic [OutW-1:0] kick_component(
      input logic signed [DiffW-1:0] d, input logic [GmW-1:0] gm,
      input logic [StepW-1:0] ts, input logic [WideW-1:0] r6,
      input bit neg_when_pos, output bit clipped);
      logic [DiffW-1:0] mag;
      logic [WideW-1:0] num;
      logic [WideW-1:0] num2;
      logic [WideW-1:0] trial;
      logic [OutW-1:0]  q;
      logic [OutW-1:0]  cand;
      bit               neg;
      clipped = 0;
      mag = d[DiffW-1] ? (~d + 1'b1) : d;
      if (mag == 0) return '0;
      num  = (WideW'(mag) * WideW'(ts) * WideW'(gm)) << NormSh;
      num2 = num * num;
      q = '0;
      for (int b = OutW - 1; b >= 0; b--) begin
         cand = q | (OutW'(1) << b);
         trial = WideW'(cand) * WideW'(cand) * r6;
         if (trial <= num2) q = cand;
      end
      neg = neg_when_pos ? (d > 0) : (d < 0);
      if (!neg) begin
         if (q > {1'b0, {(OutW-1){1'b1}}}) begin
            q = {1'b0, {(OutW-1){1'b1}}};
            clipped = 1;
         end
         return q;
      end
      if (q > {1'b1, {(OutW-1){1'b0}}}) begin
         q = {1'b1, {(OutW-1){1'b0}}};
         clipped = 1;
      end
      return -q;
   endfunction

   function automatic delta_type predict_kick(input pair_type p);
      delta_type               r;
      logic signed [DiffW-1:0] d [3];
      logic [DiffW-1:0]        m;
      logic [WideW-1:0]        r2;
      logic [WideW-1:0]        r6;
      bit                      c;
      r2 = '0;
      r.sat = 0;
      r.coin = 0;
      for (int i = 0; i < 3; i++) begin
         d[i] = DiffW'(p.pa[i]) - DiffW'(p.pb[i]);
         m = d[i][DiffW-1] ? (~d[i] + 1'b1) : d[i];
         r2 += WideW'(m) * WideW'(m);
      end
      for (int i = 0; i < 6; i++) r.dv[i] = '0;
      if (r2 == 0) begin
         r.coin = 1;
         return r;
      end
      r6 = r2 * r2 * r2;
      for (int i = 0; i < 3; i++) begin
         r.dv[i] = kick_component(d[i], p.gmb, p.ts, r6, 1, c);
         r.sat |= c;
         r.dv[i+3] = kick_component(d[i], p.gma, p.ts, r6, 0, c);
         r.sat |= c;
      end
      return r;
   endfunction

   // caller sits at a rising edge; returns at the edge of the transfer
   task automatic send_pair(input pair_type p);
      int gap;
      if (!no_gaps && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 11);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.pos_ax <= p.pa[0];
      req_ch.pos_ay <= p.pa[1];
      req_ch.pos_az <= p.pa[2];
      req_ch.pos_bx <= p.pb[0];
      req_ch.pos_by <= p.pb[1];
      req_ch.pos_bz <= p.pb[2];
      req_ch.gmass_a   <= p.gma;
      req_ch.gmass_b   <= p.gmb;
      req_ch.time_step <= p.ts;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_deltas = {expected_deltas, predict_kick(p)};
   endtask

   function automatic pair_type make_pair(input int ax, ay, az, bx, by, bz,
                                          input logic [31:0] ga, gb, ts);
      pair_type p;
      p.pa[0] = ax; p.pa[1] = ay; p.pa[2] = az;
      p.pb[0] = bx; p.pb[1] = by; p.pb[2] = bz;
      p.gma = ga; p.gmb = gb; p.ts = ts;
      return p;
   endfunction

   function automatic pair_type random_pair(input bit close);
      pair_type p;
      int       span;
      span = $urandom_range(0, 3) == 0 ? 1 << $urandom_range(0, 30) : 1 << $urandom_range(0, 12);
      for (int i = 0; i < 3; i++) begin
         p.pa[i] = $urandom;
         p.pb[i] = close ? p.pa[i] + int'($urandom_range(0, 2 * span)) - span : $urandom;
      end
      p.gma = $urandom_range(0, 7) == 0 ? $urandom_range(0, 3) : $urandom;
      p.gmb = $urandom_range(0, 7) == 0 ? $urandom_range(0, 3) : $urandom;
      p.ts  = $urandom_range(0, 7) == 0 ? $urandom_range(0, 3) : $urandom;
      return p;
   endfunction

   task automatic test_coincident();
      send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_pair(make_pair(PosMin, 2147483647, 5, PosMin, 2147483647, 5,
                          '1, '1, '1));
      send_pair(make_pair(-7, 9, 3, -7, 9, 3, 100, 200, 32'h0001_0000));
   endtask

   task automatic test_zero_terms();
      send_pair(make_pair(10, 0, 0, 0, 0, 0, 0, 1000, 32'h0001_0000));
      send_pair(make_pair(0, 10, 0, 0, 0, 0, 1000, 0, 32'h0001_0000));
      send_pair(make_pair(0, 0, 10, 0, 0, 0, 1000, 1000, 0));
      send_pair(make_pair(3, 0, -4, 0, 0, 0, 5000, 7000, 32'h0002_8000));
   endtask

   task automatic test_extremes();
      send_pair(make_pair(2147483647, 2147483647, 2147483647,
                          PosMin, PosMin, PosMin, '1, '1, '1));
      send_pair(make_pair(PosMin, PosMin, PosMin,
                          2147483647, 2147483647, 2147483647, '1, '1, '1));
      send_pair(make_pair(2147483647, PosMin, 0, PosMin, 2147483647, 0,
                          '1, 1, 1));
   endtask

   task automatic test_saturation();
      send_pair(make_pair(1, 0, 0, 0, 0, 0, '1, '1, '1));
      send_pair(make_pair(0, -1, 0, 0, 0, 0, '1, 1, '1));
      send_pair(make_pair(0, 0, 1, 0, 0, 0, 1, '1, '1));
      send_pair(make_pair(1, 1, -1, 0, 0, 0, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000));
      send_pair(make_pair(-1, 1, 1, 0, 0, 0, 32'h0000_1000, 32'h0010_0000, 32'h0001_0000));
   endtask

   task automatic test_random_pairs(input int count);
      for (int n = 0; n < count; n++)
         send_pair(random_pair($urandom_range(0, 4) != 0));
   endtask

   // response side stall bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!no_gaps && $urandom_range(0, 5) == 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= $urandom_range(0, 10);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // result checker
   always @(posedge clock) begin
      delta_type exp_d;
      delta_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.dv[0] = rsp_ch.dv_ax; got.dv[1] = rsp_ch.dv_ay; got.dv[2] = rsp_ch.dv_az;
         got.dv[3] = rsp_ch.dv_bx; got.dv[4] = rsp_ch.dv_by; got.dv[5] = rsp_ch.dv_bz;
         got.coin = rsp_ch.coincident;
         got.sat  = rsp_ch.saturated;
         if (expected_deltas.size() == 0) begin
            $display("%0t: unexpected result transfer", $time);
            error_count++;
         end else begin
            exp_d = expected_deltas.pop_front();
            for (int i = 0; i < 6; i++)
               if (got.dv[i] !== exp_d.dv[i]) begin
                  $display("%0t: dv[%0d] expected %h actual %h", $time, i,
                           exp_d.dv[i], got.dv[i]);
                  error_count++;
               end
            if (got.coin !== exp_d.coin) begin
               $display("%0t: coincident expected %b actual %b", $time, exp_d.coin, got.coin);
               error_count++;
            end
            if (got.sat !== exp_d.sat) begin
               $display("%0t: saturated expected %b actual %b", $time, exp_d.sat, got.sat);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= WatchMax) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      int wait_cycles;
      clock = 1'b0;
      reset = 1'b1;
      no_gaps = 0;
      req_ch.valid = 1'b0;
      req_ch.pos_ax = '0; req_ch.pos_ay = '0; req_ch.pos_az = '0;
      req_ch.pos_bx = '0; req_ch.pos_by = '0; req_ch.pos_bz = '0;
      req_ch.gmass_a = '0; req_ch.gmass_b = '0; req_ch.time_step = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_coincident();
      test_zero_terms();
      test_extremes();
      test_saturation();
      test_random_pairs(480);
      no_gaps = 1;
      test_random_pairs(100);
      req_ch.valid <= 1'b0;

      wait_cycles = 0;
      while (expected_deltas.size() != 0 && wait_cycles < 10 * WatchMax) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (50) @(posedge clock);
      if (expected_deltas.size() != 0)
         $display("%0t: %0d results never arrived", $time, expected_deltas.size());
      if (error_count == 0 && expected_deltas.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+sv
sv/pgd_pkg.sv
sv/pgd_if.sv
sv/pgd_front.sv
sv/pgd_fifo.sv
sv/pgd_core.sv
sv/pairwise_gravity_delta_v.sv
sv/pgd_checker.sv
verif/pairwise_gravity_delta_v_test.sv
